// ----- design/page_alias_registry_top_defines.svh -----
// Assertion macros for the page alias registry.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef PAGE_ALIAS_REGISTRY_TOP_DEFINES_SVH
`define PAGE_ALIAS_REGISTRY_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PAR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("page alias registry check failed");

// Next-cycle implication, disabled during reset.
`define PAR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("page alias registry check failed");

`endif

// ----- design/par_pkg.sv -----
// Shared types and constants of the page alias registry.
// No dependencies; used by the interfaces and all modules.
package par_pkg;

  localparam int unsigned VIRT_W   = 64;
  localparam int unsigned PHYS_W   = 48;
  localparam int unsigned STATUS_W = 3;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_UPDATED  = 3'd0,
    STATUS_APPENDED = 3'd1,
    STATUS_FULL     = 3'd2,
    STATUS_HIT      = 3'd3,
    STATUS_MISS     = 3'd4
  } par_status_e;

  // Write request from the sequencer to the table
  typedef struct packed {
    logic              virt_en;
    logic              phys_en;
    logic [VIRT_W-1:0] virt;
    logic [PHYS_W-1:0] phys;
  } par_wr_t;

endpackage

// ----- design/par_if.sv -----
// Valid/ready channel interfaces for requests and responses.
// Depends on par_pkg for field widths.
interface par_req_if import par_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [VIRT_W-1:0] virt_addr;
  logic [PHYS_W-1:0] phys_addr;

  modport source (output valid, command, virt_addr, phys_addr, input ready);
  modport sink   (input valid, command, virt_addr, phys_addr, output ready);
endinterface

interface par_rsp_if import par_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PHYS_W-1:0]   found_phys;

  modport source (output valid, status, found_phys, input ready);
  modport sink   (input valid, status, found_phys, output ready);
endinterface

// ----- design/page_alias_registry_top.sv -----
// Top level: sequencer plus entry table. An accepted request scans the valid entries
// in order until a match or the end, then loads its result into the output register.
// One item at a time; the block is ready again in the cycle after its result is loaded.
// Reset (rst_ni low, async) empties the table; no clearing pass is needed.
module page_alias_registry_top import par_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  par_req_if.sink   req_i,
  par_rsp_if.source rsp_o
);

`include "page_alias_registry_top_defines.svh"

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  par_wr_t           wr;
  logic [IdxW-1:0]   waddr;
  logic              rd_en;
  logic [IdxW-1:0]   raddr;
  logic [VIRT_W-1:0] rd_virt;
  logic [PHYS_W-1:0] rd_phys;

  par_seq #(
    .Capacity (CAPACITY),
    .IdxW     (IdxW),
    .CntW     (CntW)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .wr_o      (wr),
    .waddr_o   (waddr),
    .rd_en_o   (rd_en),
    .raddr_o   (raddr),
    .rd_virt_i (rd_virt),
    .rd_phys_i (rd_phys)
  );

  par_table #(
    .Depth (CAPACITY),
    .IdxW  (IdxW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .waddr_i   (waddr),
    .rd_en_i   (rd_en),
    .raddr_i   (raddr),
    .rd_virt_o (rd_virt),
    .rd_phys_o (rd_phys)
  );

  // The sequencer takes one item at a time
  `PAR_ASSERT_NEXT(a_busy_after_accept, req_i.valid && req_i.ready, !req_i.ready)
  // Only a lookup hit carries a physical address
  `PAR_ASSERT_NOW(a_phys_only_on_hit, rsp_o.valid && (rsp_o.status != STATUS_HIT), rsp_o.found_phys == '0)
  // A table write never coincides with an accepted request
  `PAR_ASSERT_NOW(a_no_write_when_idle, req_i.ready, !wr.virt_en && !wr.phys_en)

endmodule

// ----- design/par_table.sv -----
// Entry storage: virtual keys and physical addresses, one write port and
// one registered read port. Depends on par_pkg.
module par_table import par_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic              clk_i,
  input  par_wr_t           wr_i,
  input  logic [IdxW-1:0]   waddr_i,
  input  logic              rd_en_i,
  input  logic [IdxW-1:0]   raddr_i,
  output logic [VIRT_W-1:0] rd_virt_o,
  output logic [PHYS_W-1:0] rd_phys_o
);

  logic [VIRT_W-1:0] virt_mem [Depth];
  logic [PHYS_W-1:0] phys_mem [Depth];
  logic [VIRT_W-1:0] rd_virt_q;
  logic [PHYS_W-1:0] rd_phys_q;

  // Write entries, read one entry per cycle while rd_en_i is set into the output register
  always_ff @(posedge clk_i) begin
    if (wr_i.virt_en) begin
      virt_mem[waddr_i] <= wr_i.virt;
    end
    if (wr_i.phys_en) begin
      phys_mem[waddr_i] <= wr_i.phys;
    end
    if (rd_en_i) begin
      rd_virt_q <= virt_mem[raddr_i];
      rd_phys_q <= phys_mem[raddr_i];
    end
  end

  assign rd_virt_o = rd_virt_q;
  assign rd_phys_o = rd_phys_q;

endmodule

// ----- design/par_seq.sv -----
// Scan sequencer: walks the valid entries one per cycle through a single
// key comparator, then updates, appends or answers. Depends on par_pkg.
module par_seq import par_pkg::*; #(
  parameter int unsigned Capacity = 16,
  parameter int unsigned IdxW     = 4,
  parameter int unsigned CntW     = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  par_req_if.sink           req_i,
  par_rsp_if.source         rsp_o,
  output par_wr_t           wr_o,
  output logic [IdxW-1:0]   waddr_o,
  output logic              rd_en_o,
  output logic [IdxW-1:0]   raddr_o,
  input  logic [VIRT_W-1:0] rd_virt_i,
  input  logic [PHYS_W-1:0] rd_phys_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e            state_q;
  logic              cmd_q;
  logic [VIRT_W-1:0] key_q;
  logic [PHYS_W-1:0] pa_q;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   scan_q;
  logic              pend_q;
  logic [IdxW-1:0]   pend_idx_q;
  par_status_e       res_status_q;
  logic [PHYS_W-1:0] res_phys_q;
  logic              rsp_valid_q;
  par_status_e       rsp_status_q;
  logic [PHYS_W-1:0] rsp_phys_q;

  logic        issue;
  logic        match;
  logic        exhausted;
  logic        has_room;
  par_status_e status_d;
  logic [PHYS_W-1:0] phys_d;

  // Scan control and the shared key compare
  always_comb begin
    issue     = (state_q == S_SCAN) && (scan_q < count_q);
    match     = (state_q == S_SCAN) && pend_q && (rd_virt_i == key_q);
    exhausted = (state_q == S_SCAN) && !pend_q && !(scan_q < count_q);
    has_room  = count_q < CntW'(Capacity);

    rd_en_o = issue;
    raddr_o = scan_q[IdxW-1:0];

    wr_o      = '0;
    wr_o.virt = key_q;
    wr_o.phys = pa_q;
    waddr_o   = pend_idx_q;
    status_d  = STATUS_MISS;
    phys_d    = '0;

    priority if (match) begin
      if (cmd_q == CMD_INSERT) begin
        wr_o.phys_en = 1'b1;
        status_d     = STATUS_UPDATED;
      end else begin
        status_d = STATUS_HIT;
        phys_d   = rd_phys_i;
      end
    end else if (exhausted) begin
      if (cmd_q == CMD_LOOKUP) begin
        status_d = STATUS_MISS;
      end else if (has_room) begin
        wr_o.virt_en = 1'b1;
        wr_o.phys_en = 1'b1;
        waddr_o      = count_q[IdxW-1:0];
        status_d     = STATUS_APPENDED;
      end else begin
        status_d = STATUS_FULL;
      end
    end else begin
      status_d = STATUS_MISS;
    end
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.found_phys = rsp_phys_q;

  // Hold state, entry count and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      // Drop the result once its transfer completes, unless a new one loads now
      if (rsp_valid_q && rsp_o.ready && (state_q != S_DONE)) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            cmd_q   <= req_i.command;
            key_q   <= req_i.virt_addr;
            pa_q    <= req_i.phys_addr;
            scan_q  <= '0;
            pend_q  <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend_q     <= issue;
          pend_idx_q <= scan_q[IdxW-1:0];
          if (issue) begin
            scan_q <= CntW'(scan_q + 1'b1);
          end
          if (match || exhausted) begin
            res_status_q <= status_d;
            res_phys_q   <= phys_d;
            if (wr_o.virt_en) begin
              count_q <= CntW'(count_q + 1'b1);
            end
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // Advance once the output register is free
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= res_status_q;
            rsp_phys_q   <= res_phys_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sim/par_mapping_monitor.sv -----
// Passive monitor for the page alias registry: mirrors the mapping table,
// predicts each reply and compares it with what the block returns.
// Depends on par_pkg and the request/response interfaces in par_if.sv.
module par_mapping_monitor import par_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  par_req_if          req_i,
  par_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    par_status_e       status;
    logic [PHYS_W-1:0] phys;
  } page_reply_t;

  // Shadow copy of the table; entries at or above shadow_count are never read
  logic [VIRT_W-1:0] shadow_virt [CAPACITY];
  logic [PHYS_W-1:0] shadow_phys [CAPACITY];
  int unsigned       shadow_count;

  page_reply_t awaited_reply[$];
  int unsigned mismatch_cnt;

  // Apply one request to the shadow table and return the reply it must produce
  function automatic page_reply_t resolve_page(logic cmd, logic [VIRT_W-1:0] va,
                                               logic [PHYS_W-1:0] pa);
    page_reply_t r;
    int          hit_idx;
    hit_idx = -1;
    for (int i = 0; i < int'(shadow_count); i++) begin
      if (hit_idx < 0 && shadow_virt[i] == va) hit_idx = i;
    end
    r.phys = '0;
    if (cmd == CMD_INSERT) begin
      if (hit_idx >= 0) begin
        shadow_phys[hit_idx] = pa;
        r.status = STATUS_UPDATED;
      end else if (shadow_count >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        shadow_virt[shadow_count] = va;
        shadow_phys[shadow_count] = pa;
        shadow_count++;
        r.status = STATUS_APPENDED;
      end
    end else if (hit_idx >= 0) begin
      r.status = STATUS_HIT;
      r.phys   = shadow_phys[hit_idx];
    end else begin
      r.status = STATUS_MISS;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("[%0t] mismatch on %0s: expected %0h, got %0h", $realtime, what, want, got);
    end
  endtask

  // Predict on each request transfer, check on each response transfer
  always @(posedge clk_i or negedge rst_ni) begin
    page_reply_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      mismatch_cnt = 0;
      awaited_reply.delete();
    end else begin
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (awaited_reply.size() == 0) begin
          flag_mismatch("unexpected response, status", '0, 64'(rsp_i.status));
        end else begin
          want = awaited_reply.pop_front();
          if (rsp_i.status !== want.status)
            flag_mismatch("status", 64'(want.status), 64'(rsp_i.status));
          if (rsp_i.found_phys !== want.phys)
            flag_mismatch("found_phys", 64'(want.phys), 64'(rsp_i.found_phys));
        end
      end
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        awaited_reply.push_back(resolve_page(req_i.command, req_i.virt_addr,
                                             req_i.phys_addr));
      end
    end
    fail_count_o <= mismatch_cnt;
    pending_o    <= awaited_reply.size();
  end

endmodule

// ----- sim/tb.sv -----
// Top of the page alias registry testbench: clock, reset, request stimulus,
// response back-pressure and the final verdict.
// Depends on par_pkg, par_if.sv, page_alias_registry_top and par_mapping_monitor.
module tb import par_pkg::*; ();

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned RANDOM_REQS = 1400;
  localparam int unsigned POOL_SIZE   = 20;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt;

  logic [VIRT_W-1:0] key_pool [POOL_SIZE];

  par_req_if req_if ();
  par_rsp_if rsp_if ();

  page_alias_registry_top #(.CAPACITY(CAPACITY)) DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  par_mapping_monitor #(.CAPACITY(CAPACITY)) mapping_mon (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [VIRT_W-1:0] rand_virt();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [PHYS_W-1:0] rand_phys();
    int unsigned r;
    r = $urandom_range(19, 0);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PHYS_W'({$urandom, $urandom});
  endfunction

  // Present one request and hold it until the transfer completes
  task automatic send_req(logic cmd, logic [VIRT_W-1:0] va, logic [PHYS_W-1:0] pa);
    int unsigned idle;
    idle = pick_idle();
    if (idle != 0) begin
      req_if.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.command   <= cmd;
    req_if.virt_addr <= va;
    req_if.phys_addr <= pa;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
  endtask

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Toggle response ready in random bursts and stalls
  initial begin
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = pick_idle();
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  end

  initial begin
    int unsigned pick;
    logic [VIRT_W-1:0] key;
    cycle_cnt         = 0;
    rst_n            <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.command   <= CMD_INSERT;
    req_if.virt_addr <= '0;
    req_if.phys_addr <= '0;

    // Build the key pool: extremes, random keys and near neighbors one bit apart
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) begin
      if (k % 4 == 0) key_pool[k] = key_pool[k-1] ^ (64'd1 << $urandom_range(63, 0));
      else            key_pool[k] = rand_virt();
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: both extremes miss
    send_req(CMD_LOOKUP, key_pool[0], rand_phys());
    send_req(CMD_LOOKUP, key_pool[1], '1);
    // Append the extremes, read them back, then overwrite one
    send_req(CMD_INSERT, key_pool[0], '0);
    send_req(CMD_INSERT, key_pool[1], '1);
    send_req(CMD_LOOKUP, key_pool[0], '1);
    send_req(CMD_LOOKUP, key_pool[1], '0);
    send_req(CMD_INSERT, key_pool[0], '1);
    send_req(CMD_LOOKUP, key_pool[0], rand_phys());
    // Fill the table to capacity
    for (int k = 2; k < CAPACITY; k++) send_req(CMD_INSERT, key_pool[k], rand_phys());
    // Full table: reject a new key, still update a known one
    send_req(CMD_INSERT, key_pool[CAPACITY], rand_phys());
    send_req(CMD_INSERT, key_pool[3], rand_phys());
    send_req(CMD_LOOKUP, key_pool[3], rand_phys());
    send_req(CMD_LOOKUP, key_pool[CAPACITY+1], rand_phys());

    // Random mix of updates, rejects, hits and misses
    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 75) key = key_pool[$urandom_range(POOL_SIZE-1, 0)];
      else           key = rand_virt();
      send_req($urandom_range(1, 0) ? CMD_LOOKUP : CMD_INSERT, key, rand_phys());
    end

    // Drain outstanding replies, then allow the longest scan to settle
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
